// ===== sv/mersenne_twister_generator_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the MT19937 generator
// Each macro expects clk and rst in scope; checks are off during reset.
// ----------------------------------------------------------------------------
`ifndef MERSENNE_TWISTER_GENERATOR_DEFINES_SVH
`define MERSENNE_TWISTER_GENERATOR_DEFINES_SVH

// condition holds at every edge
`define MTG_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error(msg);

// consequent holds in the same cycle as the antecedent
`define MTG_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent holds in the cycle after the antecedent
`define MTG_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/mtg_pkg.sv =====
// ----------------------------------------------------------------------------
// mtg_pkg
// Types, constants and twist/temper functions of the MT19937 generator.
// ----------------------------------------------------------------------------
package mtg_pkg;

  localparam int STATE_WORDS   = 624;
  localparam int MIDDLE_OFFSET = 397;
  localparam int IDX_W         = 10;
  localparam int WORD_W        = 32;

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [WORD_W-1:0] word_t;

  localparam word_t UPPER_BIT    = 32'h8000_0000;
  localparam word_t TWIST_MATRIX = 32'h9908_B0DF;
  localparam word_t TEMPER_B     = 32'h9D2C_5680;
  localparam word_t TEMPER_C     = 32'hEFC6_0000;

  typedef enum logic {
    CMD_LOAD     = 1'b0,
    CMD_GENERATE = 1'b1
  } cmd_t;

  // one write into the state memory
  typedef struct packed {
    logic  en;
    idx_t  addr;
    word_t data;
  } wr_port_t;

  // the three reads of one generate
  typedef struct packed {
    logic en;
    idx_t cur;
    idx_t nxt;
    idx_t mid;
  } rd_req_t;

  // pipeline status seen by the input control
  typedef struct packed {
    logic busy;     // twist stage holds a generate
    logic advance;  // twist stage can take a new generate this cycle
  } stage_status_t;

  // next index, wrapping at the end of the state
  function automatic idx_t wrap_inc(input idx_t i);
    return (i == idx_t'(STATE_WORDS - 1)) ? '0 : i + idx_t'(1);
  endfunction

  // index of the middle word, wrapping
  function automatic idx_t mid_index(input idx_t i);
    logic [IDX_W:0] s;
    s = {1'b0, i} + (IDX_W+1)'(MIDDLE_OFFSET);
    if (s >= (IDX_W+1)'(STATE_WORDS)) begin
      s = s - (IDX_W+1)'(STATE_WORDS);
    end
    return s[IDX_W-1:0];
  endfunction

  function automatic word_t twist(input word_t cur, input word_t nxt, input word_t mid);
    word_t y;
    word_t w;
    y = (cur & UPPER_BIT) | (nxt & ~UPPER_BIT);
    w = mid ^ (y >> 1);
    if (y[0]) begin
      w = w ^ TWIST_MATRIX;
    end
    return w;
  endfunction

  function automatic word_t temper(input word_t x);
    word_t y;
    y = x;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

endpackage

// ===== sv/mtg_state_mem.sv =====
// ----------------------------------------------------------------------------
// mtg_state_mem
// State words in two identical copies: copy A serves the current and next
// word, copy B the middle word. One write port feeds both; reads registered.
// ----------------------------------------------------------------------------
module mtg_state_mem
  import mtg_pkg::*;
(
  input  logic     clk,
  input  wr_port_t wr,
  input  rd_req_t  rd,
  output word_t    cur_word,
  output word_t    nxt_word,
  output word_t    mid_word
);

  word_t mem_a [STATE_WORDS];
  word_t mem_b [STATE_WORDS];

  // copy A: write, read at current and next index
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem_a[wr.addr] <= wr.data;
    end
    if (rd.en) begin
      cur_word <= mem_a[rd.cur];
      nxt_word <= mem_a[rd.nxt];
    end
  end

  // copy B: write, read at middle index
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem_b[wr.addr] <= wr.data;
    end
    if (rd.en) begin
      mid_word <= mem_b[rd.mid];
    end
  end

endmodule

// ===== sv/mtg_twist_stage.sv =====
// ----------------------------------------------------------------------------
// mtg_twist_stage
// Twists the words read for one generate, writes the new word back and
// tempers it into the output register.
// ----------------------------------------------------------------------------
module mtg_twist_stage
  import mtg_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          issue,
  input  idx_t          issue_pos,
  input  word_t         cur_word,
  input  word_t         nxt_word,
  input  word_t         mid_word,
  output stage_status_t status,
  output wr_port_t      wb,
  output logic          out_valid,
  input  logic          out_ready,
  output word_t         random_number
);

  logic  s1_valid;
  idx_t  s1_pos;
  logic  out_free;
  word_t twisted;

  assign out_free       = !out_valid || out_ready;
  assign status.busy    = s1_valid;
  assign status.advance = !s1_valid || out_free;

  // twist stage control: read data arrives with this flag
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (status.advance) begin
      s1_valid <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s1_pos <= issue_pos;
    end
  end

  assign twisted = twist(cur_word, nxt_word, mid_word);

  // write back as the word moves to the output register
  assign wb.en   = s1_valid && out_free;
  assign wb.addr = s1_pos;
  assign wb.data = twisted;

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && out_free) begin
      random_number <= temper(twisted);
    end
  end

endmodule

// ===== sv/mersenne_twister_generator.sv =====
// ----------------------------------------------------------------------------
// mersenne_twister_generator
// MT19937 generator: 624 state words loaded over the input channel, one
// tempered 32-bit number per generate word.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): command 0 loads word_value into state
// word word_index (indexes 624 and up are dropped); command 1 generates.
// Output channel (out_valid/out_ready): one random_number per generate, in
// order; loads give no output word.
// A generate accepted at an edge reads the state memory at that edge; the
// words are twisted and tempered and go to the output register once it is
// free. A generate is accepted every cycle while the output is taken; the
// rate is set by the state memory, which serves the current, next and middle
// words from two copies and takes the write-back on its single write port.
// A load is held off while the twist stage holds a write-back for that port.
// Reset clears the position to word 0 and empties the pipeline; the state
// words are not cleared and must all be loaded before generating.
// When the receiver stalls, the output register and twist stage hold their
// words; in_ready drops once the twist stage is full until the output drains.
// ----------------------------------------------------------------------------
`include "mersenne_twister_generator_defines.svh"

module mersenne_twister_generator
  import mtg_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        command,
  input  logic [9:0]  word_index,
  input  logic [31:0] word_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] random_number
);

  idx_t          position;
  logic          gen_acc;
  logic          load_acc;
  logic          load_wr;
  rd_req_t       rd;
  wr_port_t      wb;
  wr_port_t      wr;
  stage_status_t status;
  word_t         cur_word;
  word_t         nxt_word;
  word_t         mid_word;

  // input handshake: a load waits out a pending write-back
  assign in_ready = (command == CMD_GENERATE) ? status.advance : !status.busy;
  assign gen_acc  = in_valid && in_ready && (command == CMD_GENERATE);
  assign load_acc = in_valid && in_ready && (command == CMD_LOAD);
  assign load_wr  = load_acc && (word_index < idx_t'(STATE_WORDS));

  // position advances on every generate
  always_ff @(posedge clk) begin
    if (rst) begin
      position <= '0;
    end else if (gen_acc) begin
      position <= wrap_inc(position);
    end
  end

  // memory reads for a generate
  assign rd.en  = gen_acc;
  assign rd.cur = position;
  assign rd.nxt = wrap_inc(position);
  assign rd.mid = mid_index(position);

  // single write port: write-back or load
  always_comb begin
    if (wb.en) begin
      wr = wb;
    end else begin
      wr.en   = load_wr;
      wr.addr = word_index;
      wr.data = word_value;
    end
  end

  mtg_state_mem u_mem (
    .clk      (clk),
    .wr       (wr),
    .rd       (rd),
    .cur_word (cur_word),
    .nxt_word (nxt_word),
    .mid_word (mid_word)
  );

  mtg_twist_stage u_twist (
    .clk           (clk),
    .rst           (rst),
    .issue         (gen_acc),
    .issue_pos     (position),
    .cur_word      (cur_word),
    .nxt_word      (nxt_word),
    .mid_word      (mid_word),
    .status        (status),
    .wb            (wb),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .random_number (random_number)
  );

  `MTG_ASSERT_ALWAYS(a_pos_range, position < idx_t'(STATE_WORDS), "position out of range")
  `MTG_ASSERT_IMP(a_wr_clash, wb.en, !load_acc, "load collides with write-back")
  `MTG_ASSERT_NXT(a_pos_step, gen_acc, position == wrap_inc($past(position)), "position skipped")
  `MTG_ASSERT_NXT(a_load_pos, load_acc, $stable(position), "load moved position")
  `MTG_ASSERT_NXT(a_gen_stage, gen_acc, status.busy, "generate lost before twist")

endmodule

// ===== tb/sv/tb_mersenne_twister_generator.sv =====
// ----------------------------------------------------------------------------
// tb_mersenne_twister_generator
// Self-checking bench for the MT19937 generator. It seeds all 624 state words,
// then runs directed and random load/generate traffic with random stalls on
// both channels. A local model of the state and position predicts every
// tempered number, and the numbers are checked in order.
// ----------------------------------------------------------------------------
module tb_mersenne_twister_generator
  import mtg_pkg::*;
();

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        command = 1'b0;
  logic [9:0]  word_index = '0;
  logic [31:0] word_value = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] random_number;

  mersenne_twister_generator DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .command      (command),
    .word_index   (word_index),
    .word_value   (word_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .random_number(random_number)
  );

  always #4 clk = ~clk;

  // local copy of the generator state
  word_t       shadow_words [STATE_WORDS];
  int unsigned shadow_pos;
  bit          last_word_twisted;

  word_t       expected_numbers [$];
  int unsigned error_count;
  bit          burst_mode;

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $time, what);
    error_count++;
  endtask

  function automatic word_t temper_word(input word_t x);
    word_t t;
    t = x;
    t = t ^ (t >> 11);
    t = t ^ ((t << 7) & TEMPER_B);
    t = t ^ ((t << 15) & TEMPER_C);
    t = t ^ (t >> 18);
    return t;
  endfunction

  // twist the word at the position, advance, return the tempered number
  function automatic word_t predict_generate();
    int unsigned nb;
    int unsigned md;
    word_t       mix;
    word_t       fresh;
    nb    = (shadow_pos + 1) % STATE_WORDS;
    md    = (shadow_pos + MIDDLE_OFFSET) % STATE_WORDS;
    mix   = {shadow_words[shadow_pos][31], shadow_words[nb][30:0]};
    fresh = shadow_words[md] ^ (mix >> 1);
    if (mix[0]) begin
      fresh = fresh ^ TWIST_MATRIX;
    end
    shadow_words[shadow_pos] = fresh;
    if (shadow_pos == STATE_WORDS - 1) begin
      last_word_twisted = 1'b1;
    end
    shadow_pos = nb;
    return temper_word(fresh);
  endfunction

  // one word on the input channel; the model is updated at acceptance
  task automatic send_word(input cmd_t cmd, input idx_t idx, input word_t val);
    if (!burst_mode && $urandom_range(0, 99) < 20) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    command    <= cmd;
    word_index <= idx;
    word_value <= val;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (cmd == CMD_GENERATE) begin
      expected_numbers.push_back(predict_generate());
    end else if (idx < STATE_WORDS) begin
      shadow_words[idx] = val;
    end
  endtask

  function automatic idx_t near_position(input int unsigned offset);
    return idx_t'((shadow_pos + offset) % STATE_WORDS);
  endfunction

  // hold the input idle until every number has come out
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_numbers.size() != 0) @(posedge clk);
  endtask

  // receiver stalls
  always @(posedge clk) begin
    out_ready <= burst_mode || ($urandom_range(0, 99) >= 20);
  end

  // output check
  always @(posedge clk) begin : check_numbers
    word_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_numbers.size() == 0) begin
        report_mismatch($sformatf("unexpected number %h", random_number));
      end else begin
        want = expected_numbers.pop_front();
        if (random_number !== want) begin
          report_mismatch($sformatf("random_number %h, want %h", random_number, want));
        end
      end
    end
  end

  task automatic reset_block();
    foreach (shadow_words[i]) shadow_words[i] = '0;
    shadow_pos        = 0;
    last_word_twisted = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
  endtask

  // standard seeding from 5489, so no generate ever reads an unloaded word
  task automatic test_seed_state();
    word_t v;
    v = 32'd5489;
    for (int i = 0; i < STATE_WORDS; i++) begin
      send_word(CMD_LOAD, idx_t'(i), v);
      v = 32'd1812433253 * (v ^ (v >> 30)) + word_t'(i + 1);
    end
  endtask

  // field extremes, dropped loads and write/read hazards, back to back
  task automatic test_directed();
    burst_mode = 1'b1;
    send_word(CMD_GENERATE, 10'h3FF, 32'hFFFF_FFFF);
    send_word(CMD_GENERATE, 10'h000, 32'h0000_0000);
    send_word(CMD_LOAD, 10'd624, 32'hFFFF_FFFF);
    send_word(CMD_LOAD, 10'h3FF, 32'h0000_0000);
    send_word(CMD_LOAD, 10'h3FF, 32'hFFFF_FFFF);
    send_word(CMD_GENERATE, 10'd5, 32'h1234_5678);
    send_word(CMD_LOAD, near_position(0), 32'hFFFF_FFFF);
    send_word(CMD_GENERATE, '0, '0);
    send_word(CMD_LOAD, near_position(1), 32'h0000_0000);
    send_word(CMD_LOAD, near_position(MIDDLE_OFFSET), 32'hFFFF_FFFF);
    send_word(CMD_GENERATE, '0, '0);
    send_word(CMD_GENERATE, '0, '0);
    send_word(CMD_LOAD, near_position(STATE_WORDS - 1), 32'h8000_0000);
    send_word(CMD_GENERATE, '0, '0);
    send_word(CMD_LOAD, 10'd0, 32'h7FFF_FFFF);
    send_word(CMD_LOAD, 10'd623, 32'hFFFF_FFFF);
    repeat (4) send_word(CMD_GENERATE, '0, '0);
    burst_mode = 1'b0;
    wait_drained();
  endtask

  // mostly generates; loads aimed near the position to hit pipeline hazards
  task automatic test_random_traffic(input int unsigned count);
    int unsigned done;
    int unsigned pick;
    idx_t        idx;
    done = 0;
    while (done < count) begin
      burst_mode = (done >= count / 3) && (done < count / 3 + 200);
      if ($urandom_range(0, 99) < 65) begin
        send_word(CMD_GENERATE, idx_t'($urandom), $urandom);
        done++;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
          case ($urandom_range(0, 3))
            0:       idx = near_position(0);
            1:       idx = near_position(1);
            2:       idx = near_position(MIDDLE_OFFSET);
            default: idx = near_position(STATE_WORDS - 1);
          endcase
        end else if (pick < 85) begin
          idx = idx_t'($urandom_range(0, STATE_WORDS - 1));
        end else begin
          idx = idx_t'($urandom_range(STATE_WORDS, 1023));
        end
        send_word(CMD_LOAD, idx, $urandom);
        if (idx < STATE_WORDS) done++;
      end
    end
    burst_mode = 1'b0;
  endtask

  // make sure the last word has been twisted with word 0 as its neighbor
  task automatic test_position_wrap();
    while (!last_word_twisted) begin
      send_word(CMD_GENERATE, idx_t'($urandom), $urandom);
    end
    repeat (3) send_word(CMD_GENERATE, idx_t'($urandom), $urandom);
  endtask

  initial begin : main
    int unsigned guard;
    error_count = 0;
    burst_mode  = 1'b0;
    reset_block();
    test_seed_state();
    test_directed();
    test_random_traffic(300);
    test_position_wrap();
    in_valid <= 1'b0;
    guard = 0;
    while (expected_numbers.size() != 0 && guard < 10000) begin
      @(posedge clk);
      guard++;
    end
    if (expected_numbers.size() != 0) begin
      report_mismatch($sformatf("%0d numbers never came out", expected_numbers.size()));
    end
    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("tb_mersenne_twister_generator: clean");
    end else begin
      $display("tb_mersenne_twister_generator: errors");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("tb_mersenne_twister_generator: errors");
    $finish;
  end

endmodule
